// ===== src/clb_pkg.sv =====
// shared types, codes and constants of the command line buffer tokenizer
`default_nettype none

package clb_pkg;

   // default store depth in bytes
   localparam int DEFAULT_BUFFER_DEPTH = 64;

   // fixed field widths
   localparam int ACTION_W = 2;
   localparam int CHAR_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 6;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FETCH = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ENDED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

   // special keys
   localparam logic [CHAR_W-1:0] KEY_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] KEY_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] KEY_ERASE   = 8'd8;
   localparam logic [CHAR_W-1:0] KEY_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] KEY_NULL    = 8'd0;

   // result of one transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                arg_found;
      logic [OFFSET_W-1:0] arg_offset;
   } res_type;

endpackage

`default_nettype wire

// ===== src/clb_if.sv =====
// request and response channel interfaces
`default_nettype none

interface clb_req_if;
   import clb_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAR_W-1:0]   char_in;

   modport source (output valid, output action, output char_in, input ready);
   modport sink   (input valid, input action, input char_in, output ready);
endinterface

interface clb_rsp_if;
   import clb_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                arg_found;
   logic [OFFSET_W-1:0] arg_offset;

   modport source (output valid, output status, output arg_found, output arg_offset,
                   input ready);
   modport sink   (input valid, input status, input arg_found, input arg_offset,
                   output ready);
endinterface

`default_nettype wire

// ===== src/command_line_buffer_tokenizer.sv =====
// command line buffer with argument tokenizer, top level
//
//   channel   direction  payload                            handshake
//   req_chan  in         action, char_in                    valid / ready
//   rsp_chan  out        status, arg_found, arg_offset      valid / ready
//
// one transaction at a time; req_chan.ready is high only while the sequencer idles.
// put or erase writes at most one byte of the store; end of line runs the space-to-null
// walk through the single-port store read over the whole store; clear zeroes the whole store.
// fetch scans the stored bytes one by one through the same read port.
// after reset the store is zeroed before req_chan.ready rises.
// a result waits in the output register while the next transaction is taken.
`default_nettype none

module command_line_buffer_tokenizer #(
   parameter int BUFFER_DEPTH = clb_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   clb_req_if.sink    req_chan,
   clb_rsp_if.source  rsp_chan
);
   import clb_pkg::*;

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);

   logic              res_valid;
   res_type           res;
   logic              slot_free;
   logic              rsp_valid_ff;
   res_type           rsp_res_ff;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CHAR_W-1:0] mem_rd_data;

   // sequencer
   clb_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_action  (req_chan.action),
      .req_char    (req_chan.char_in),
      .req_ready   (req_chan.ready),
      .slot_free   (slot_free),
      .res_valid   (res_valid),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // line store
   clb_mem #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (slot_free) begin
         rsp_valid_ff <= res_valid;
      end
      if (slot_free && res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_res_ff.status;
   assign rsp_chan.arg_found  = rsp_res_ff.arg_found;
   assign rsp_chan.arg_offset = rsp_res_ff.arg_offset;
endmodule

`default_nettype wire

// ===== src/clb_mem.sv =====
// line store: one write port, one registered read port
`default_nettype none

module clb_mem #(
   parameter int  BUFFER_DEPTH = clb_pkg::DEFAULT_BUFFER_DEPTH,
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [clb_pkg::CHAR_W-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [clb_pkg::CHAR_W-1:0]  rd_data
);
   import clb_pkg::*;

   logic [CHAR_W-1:0] store_mem [BUFFER_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== src/clb_ctrl.sv =====
// sequencer with the byte compares and pointer increments
`default_nettype none

module clb_ctrl #(
   parameter int  BUFFER_DEPTH = clb_pkg::DEFAULT_BUFFER_DEPTH,
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [clb_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [clb_pkg::CHAR_W-1:0]    req_char,
   output logic                               req_ready,
   input  wire logic                          slot_free,
   output logic                               res_valid,
   output clb_pkg::res_type                   res,
   output logic                               mem_wr_en,
   output logic      [ADDR_W-1:0]             mem_wr_addr,
   output logic      [clb_pkg::CHAR_W-1:0]    mem_wr_data,
   output logic      [ADDR_W-1:0]             mem_rd_addr,
   input  wire logic [clb_pkg::CHAR_W-1:0]    mem_rd_data
);
   import clb_pkg::*;

   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FILL_MAX  = CNT_W'(BUFFER_DEPTH - 1);
   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK_RD,
      S_WALK_CHK,
      S_FETCH_RD,
      S_FETCH_CHK,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              line_done_ff, line_done_in;
   logic              first_ff, first_in;
   logic              clr_reply_ff, clr_reply_in;
   res_type           res_ff, res_in;

   logic [CNT_W-1:0]  fill_dec;
   logic [CNT_W-1:0]  scan_next;
   logic              accept;

   assign fill_dec  = fill_ff - 1'b1;
   assign scan_next = scan_ff + 1'b1;
   assign accept    = req_valid && (state_ff == S_IDLE);

   // next state and store access
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      line_done_in = line_done_ff;
      first_in     = first_ff;
      clr_reply_in = clr_reply_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ptr_ff;
      mem_wr_data  = KEY_NULL;
      mem_rd_addr  = ptr_ff;

      case (state_ff)
         // zero sweep after reset or clear
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            if (ptr_ff == LAST_ADDR) begin
               ptr_in       = '0;
               clr_reply_in = 1'b0;
               state_in     = clr_reply_ff ? S_DONE : S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = S_DONE;
               case (req_action)
                  ACT_PUT: begin
                     if (line_done_ff) begin
                        res_in.status = ST_ENDED;
                     end else if (req_char == KEY_NEWLINE || req_char == KEY_RETURN) begin
                        res_in.status = ST_ENDED;
                        line_done_in  = 1'b1;
                        ptr_in        = '0;
                        state_in      = S_WALK_RD;
                     end else if (req_char == KEY_ERASE) begin
                        if (fill_ff == '0) begin
                           res_in.status = ST_REFUSED;
                        end else begin
                           fill_in     = fill_dec;
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = fill_dec[ADDR_W-1:0];
                           mem_wr_data = KEY_NULL;
                        end
                     end else if (fill_ff >= FILL_MAX) begin
                        res_in.status = ST_REFUSED;
                     end else begin
                        fill_in     = fill_ff + 1'b1;
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = fill_ff[ADDR_W-1:0];
                        mem_wr_data = req_char;
                     end
                  end
                  ACT_CLEAR: begin
                     fill_in      = '0;
                     scan_in      = '0;
                     line_done_in = 1'b0;
                     first_in     = 1'b1;
                     clr_reply_in = 1'b1;
                     ptr_in       = '0;
                     state_in     = S_CLEAR;
                  end
                  ACT_FETCH: begin
                     if (first_ff) begin
                        first_in         = 1'b0;
                        res_in.arg_found = 1'b1;
                     end else if (scan_ff < DEPTH_CNT) begin
                        state_in = S_FETCH_RD;
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end

         // space to null walk over the whole store
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end

         S_WALK_CHK: begin
            if (mem_rd_data == KEY_SPACE) begin
               mem_wr_en = 1'b1;
            end
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = S_DONE;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_WALK_RD;
            end
         end

         // argument scan, one byte per read
         S_FETCH_RD: begin
            mem_rd_addr = scan_ff[ADDR_W-1:0];
            state_in    = S_FETCH_CHK;
         end

         S_FETCH_CHK: begin
            scan_in  = scan_next;
            state_in = S_DONE;
            if (scan_next >= fill_ff) begin
               res_in = '0;
            end else if (mem_rd_data == KEY_NULL) begin
               res_in.arg_found  = 1'b1;
               res_in.arg_offset = OFFSET_W'(scan_next);
            end else if (scan_next != DEPTH_CNT) begin
               state_in = S_FETCH_RD;
            end
         end

         // result waits for the output register
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         line_done_ff <= 1'b0;
         first_ff     <= 1'b1;
         clr_reply_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         line_done_ff <= line_done_in;
         first_ff     <= first_in;
         clr_reply_ff <= clr_reply_in;
      end
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // an ordinary byte with room grows the line by one
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_PUT && !line_done_ff && req_char != KEY_NEWLINE &&
       req_char != KEY_RETURN && req_char != KEY_ERASE && fill_ff < FILL_MAX)
      |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("fill count did not advance on an accepted byte");

   // the line ends only through an accepted newline or return
   assert property (@(posedge clock) disable iff (reset)
      $rose(line_done_ff) |-> ($past(accept) && $past(req_action) == ACT_PUT &&
         ($past(req_char) == KEY_NEWLINE || $past(req_char) == KEY_RETURN)))
      else $error("line ended without an end key");

   // counters stay within the store
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FILL_MAX) && (scan_ff <= DEPTH_CNT))
      else $error("fill count or scan position out of range");

   // a scan step never starts past the end of the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH_RD) |-> (scan_ff < DEPTH_CNT) && !first_ff)
      else $error("argument scan started out of range");
endmodule

`default_nettype wire
